// File: design/ipfc_pkg.sv
package ipfc_pkg;
    typedef enum logic [2:0] {
        V_TCP       = 3'd0,
        V_UDP       = 3'd1,
        V_ICMP      = 3'd2,
        V_ICMPV6    = 3'd3,
        V_BAD_HLEN  = 3'd4,
        V_BAD_CSUM  = 3'd5,
        V_UNKNOWN   = 3'd6
    } t_verdict;

    localparam logic [7:0] PROTO_ICMP   = 8'd1;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [7:0] PROTO_ICMPV6 = 8'd58;
    localparam logic [5:0] MIN_IHL      = 6'd20;
    localparam logic [5:0] V6_HLEN      = 6'd40;

    // Packet summary handed from the framer to the reporting stage.
    typedef struct packed {
        logic        is_ipv6;
        logic [7:0]  proto;
        logic [16:0] plen;
        logic [5:0]  hlen;
        logic        csum_ok;
        logic [63:0] src_hi;
        logic [63:0] src_lo;
        logic [63:0] dst_hi;
        logic [63:0] dst_lo;
    } t_frame;

    typedef struct packed {
        logic [2:0]  verdict;
        logic        is_ipv6;
        logic [7:0]  protocol_number;
        logic [16:0] packet_length;
        logic [5:0]  header_length;
        logic [15:0] payload_length;
        logic [63:0] source_high;
        logic [63:0] source_low;
        logic [63:0] dest_high;
        logic [63:0] dest_low;
        logic [31:0] packets_seen;
        logic [31:0] packets_dropped;
    } t_result;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_read;
    } t_in_word;

    function automatic logic [2:0] classify(input logic [7:0] p);
        logic [2:0] v;
        case (p)
            PROTO_TCP:    v = V_TCP;
            PROTO_UDP:    v = V_UDP;
            PROTO_ICMP:   v = V_ICMP;
            PROTO_ICMPV6: v = V_ICMPV6;
            default:      v = V_UNKNOWN;
        endcase
        return v;
    endfunction
endpackage

// File: design/ipfc_if.sv
interface ipfc_in_if;
    logic                 valid;
    logic                 ready;
    ipfc_pkg::t_in_word   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ipfc_out_if;
    logic                 valid;
    logic                 ready;
    ipfc_pkg::t_result    payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: design/ipfc_framer.sv
module ipfc_framer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ipfc_pkg::t_in_word i_word,
    output logic              o_done,
    output ipfc_pkg::t_frame  o_frame
);
    import ipfc_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RECV, S_SKIP} t_state;

    t_state      r_state, n_state;
    logic [16:0] r_idx, n_idx;
    logic [16:0] r_flen, n_flen;
    logic        r_v6, n_v6;
    logic [5:0]  r_ihl, n_ihl;
    logic [7:0]  r_proto, n_proto;
    logic [15:0] r_sum, n_sum;
    logic [63:0] r_s0, r_s1, r_d0, r_d1, n_s0, n_s1, n_d0, n_d1;
    logic        n_done;
    logic [16:0] s;
    logic [7:0]  b;
    logic        eor;
    logic [16:0] idx;

    assign b   = i_word.data_byte;
    assign eor = i_word.end_of_read;

    always_comb begin
        n_state = r_state; n_idx = r_idx; n_flen = r_flen; n_v6 = r_v6;
        n_ihl = r_ihl; n_proto = r_proto; n_sum = r_sum;
        n_s0 = r_s0; n_s1 = r_s1; n_d0 = r_d0; n_d1 = r_d1;
        n_done = 1'b0;
        s = '0;
        idx = r_idx;
        if (i_valid) begin
            if (r_state == S_SKIP) begin
                if (eor) n_state = S_IDLE;
            end else begin
                if (r_state != S_RECV) begin
                    idx = '0; n_flen = '0; n_sum = '0; n_proto = '0;
                    n_s0 = '0; n_s1 = '0; n_d0 = '0; n_d1 = '0;
                    n_v6 = (b[7:4] == 4'd6);
                    n_ihl = {b[3:0], 2'b00};
                    n_state = S_RECV;
                end
                if (r_state != S_RECV && b[7:4] != 4'd4 && b[7:4] != 4'd6) begin
                    n_state = eor ? S_IDLE : S_SKIP;
                    n_idx = '0;
                end else if (!n_v6) begin
                    if (idx < {11'd0, n_ihl}) begin
                        s = {1'b0, n_sum} + (idx[0] ? {9'd0, b} : {1'b0, b, 8'd0});
                        n_sum = s[15:0] + {15'd0, s[16]};
                    end
                    case (idx)
                        17'd2: n_flen = {1'b0, b, 8'd0};
                        17'd3: n_flen = n_flen | {9'd0, b};
                        17'd9: n_proto = b;
                        default: begin
                            if (idx >= 17'd12 && idx < 17'd16) n_s1 = {n_s1[55:0], b};
                            else if (idx >= 17'd16 && idx < 17'd20)
                                n_d1 = {n_d1[55:0], b};
                        end
                    endcase
                    if (idx == 17'd3 && n_flen < 17'd20) begin
                        n_state = eor ? S_IDLE : S_SKIP;
                    end else if (idx >= 17'd3 && idx + 17'd1 == n_flen) begin
                        n_done = 1'b1; n_state = S_IDLE; n_idx = '0;
                    end else begin
                        n_idx = idx + 17'd1;
                        if (eor) n_state = S_IDLE;
                    end
                end else begin
                    case (idx)
                        17'd4: n_flen = {1'b0, b, 8'd0};
                        17'd5: n_flen = 17'd40 + (n_flen | {9'd0, b});
                        17'd6: n_proto = b;
                        default: begin
                            if (idx >= 17'd8 && idx < 17'd16) n_s0 = {n_s0[55:0], b};
                            else if (idx >= 17'd16 && idx < 17'd24)
                                n_s1 = {n_s1[55:0], b};
                            else if (idx >= 17'd24 && idx < 17'd32)
                                n_d0 = {n_d0[55:0], b};
                            else if (idx >= 17'd32 && idx < 17'd40)
                                n_d1 = {n_d1[55:0], b};
                        end
                    endcase
                    if (idx >= 17'd5 && idx + 17'd1 == n_flen) begin
                        n_done = 1'b1; n_state = S_IDLE; n_idx = '0;
                    end else begin
                        n_idx = idx + 17'd1;
                        if (eor) n_state = S_IDLE;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_idx <= '0; r_flen <= '0; r_v6 <= 1'b0;
            r_ihl <= '0; r_proto <= '0; r_sum <= '0;
            r_s0 <= '0; r_s1 <= '0; r_d0 <= '0; r_d1 <= '0;
            o_done <= 1'b0;
        end else begin
            r_state <= n_state; r_idx <= n_idx; r_flen <= n_flen; r_v6 <= n_v6;
            r_ihl <= n_ihl; r_proto <= n_proto; r_sum <= n_sum;
            r_s0 <= n_s0; r_s1 <= n_s1; r_d0 <= n_d0; r_d1 <= n_d1;
            o_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_done) begin
            o_frame.is_ipv6 <= n_v6;
            o_frame.proto   <= n_proto;
            o_frame.plen    <= n_flen;
            o_frame.hlen    <= n_v6 ? V6_HLEN : n_ihl;
            o_frame.csum_ok <= (n_sum == 16'hFFFF);
            o_frame.src_hi  <= n_s0;
            o_frame.src_lo  <= n_s1;
            o_frame.dst_hi  <= n_d0;
            o_frame.dst_lo  <= n_d1;
        end
    end

    // Completion only ever follows an accepted byte.
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_valid)) else $error("done without input");
    a_skip_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SKIP) |=> !o_done) else $error("result while skipping");
    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_idx == '0) else $error("index not cleared");
endmodule

// File: design/ipfc_fifo.sv
module ipfc_fifo #(
    parameter int Depth = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ipfc_pkg::t_frame i_data,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [$clog2(Depth+1)-1:0] o_count,
    output ipfc_pkg::t_frame o_data
);
    import ipfc_pkg::*;
    localparam int AW = $clog2(Depth);

    t_frame r_mem [Depth];
    logic [AW-1:0] r_wp, r_rp;
    logic [$clog2(Depth+1)-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(Depth - 1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == AW'(Depth - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (i_push ? 1'b1 : 1'b0) - (i_pop ? 1'b1 : 1'b0);
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end
    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;

    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |-> r_cnt != ($clog2(Depth+1))'(Depth)) else $error("overflow");
    a_no_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("underflow");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_push && !i_pop |=> $stable(r_cnt)) else $error("count drift");
endmodule

// File: design/ipfc_reporter.sv
module ipfc_reporter #(
    parameter int CountWidth = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_avail,
    input  ipfc_pkg::t_frame i_frame,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output ipfc_pkg::t_result o_result
);
    import ipfc_pkg::*;

    logic [CountWidth-1:0] r_seen, r_drop;
    logic [CountWidth-1:0] seen_nx, drop_nx;
    logic [2:0]  verdict;
    logic        drop;
    logic [16:0] pl;

    always_comb begin
        if (!i_frame.is_ipv6 && (i_frame.hlen < MIN_IHL ||
                                 {11'd0, i_frame.hlen} > i_frame.plen))
            verdict = V_BAD_HLEN;
        else if (!i_frame.is_ipv6 && !i_frame.csum_ok)
            verdict = V_BAD_CSUM;
        else
            verdict = classify(i_frame.proto);
    end
    assign drop  = (verdict == V_BAD_HLEN) || (verdict == V_BAD_CSUM) ||
                   (verdict == V_UNKNOWN);
    assign pl    = i_frame.plen - {11'd0, i_frame.hlen};
    assign o_pop = i_avail && (!o_valid || i_ready);

    // counts wrap at their own width before being widened for the result
    assign seen_nx = r_seen + 1'b1;
    assign drop_nx = drop ? r_drop + 1'b1 : r_drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0; r_seen <= '0; r_drop <= '0;
        end else begin
            if (o_pop) begin
                o_valid <= 1'b1;
                r_seen  <= seen_nx;
                r_drop  <= drop_nx;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_result.verdict         <= verdict;
            o_result.is_ipv6         <= i_frame.is_ipv6;
            o_result.protocol_number <= i_frame.proto;
            o_result.packet_length   <= i_frame.plen;
            o_result.header_length   <= i_frame.hlen;
            o_result.payload_length  <= drop ? 16'd0 : pl[15:0];
            o_result.source_high     <= i_frame.src_hi;
            o_result.source_low      <= i_frame.src_lo;
            o_result.dest_high       <= i_frame.dst_hi;
            o_result.dest_low        <= i_frame.dst_lo;
            o_result.packets_seen    <= 32'(seen_nx);
            o_result.packets_dropped <= 32'(drop_nx);
        end
    end

    a_drop_le_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && drop |=> o_result.verdict >= V_BAD_HLEN) else $error("drop verdict");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result lost");
    a_pl_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.verdict >= V_BAD_HLEN |-> o_result.payload_length == 16'd0)
        else $error("payload on drop");
endmodule

// File: design/ip_packet_framer_classifier_top.sv
// IPv4/IPv6 packet framer and header classifier.
// Input channel (in_ch): one word per handshake, a byte of a device read plus
// an end-of-read flag. Output channel (out_ch): one result word per complete
// framed packet, carrying verdict, lengths, addresses and running counts.
// The framer takes one byte every clock while in_ch.ready is high; it parses
// fields and folds the IPv4 header checksum as bytes arrive. On the last byte
// of a packet its summary is registered, then pushed into a four-deep queue.
// The reporter pops the queue, judges IPv4 header length and checksum,
// classifies the protocol, bumps the packet and drop counters and registers
// the result. A result passes through the framer's summary register, the
// queue and the reporter's result register. Throughput: one byte per cycle
// while in_ch.ready is high; a packet is at least 20 bytes.
// When the receiver stalls the result holds; the queue absorbs packets and
// in_ch.ready falls only when the queue could overflow.
// Reset (synchronous, active low) returns the framer to awaiting a packet
// start and clears the queue and both counters.
module ip_packet_framer_classifier_top #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ipfc_in_if.sink    in_ch,
    ipfc_out_if.source out_ch
);
    import ipfc_pkg::*;

    localparam int QDepth = 4;

    logic   acc, done, pop, empty;
    logic [$clog2(QDepth+1)-1:0] cnt;
    t_frame fr_in, fr_out;

    // Leave room for one packet that may complete from bytes in flight.
    assign in_ch.ready = (cnt < ($clog2(QDepth+1))'(QDepth - 1));
    assign acc = in_ch.valid && in_ch.ready;

    ipfc_framer u_framer (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(acc),
        .i_word(in_ch.payload), .o_done(done), .o_frame(fr_in)
    );

    ipfc_fifo #(.Depth(QDepth)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(done), .i_data(fr_in),
        .i_pop(pop), .o_empty(empty), .o_count(cnt), .o_data(fr_out)
    );

    ipfc_reporter #(.CountWidth(COUNT_WIDTH)) u_report (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_avail(!empty), .i_frame(fr_out),
        .o_pop(pop), .o_valid(out_ch.valid), .i_ready(out_ch.ready),
        .o_result(out_ch.payload)
    );

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> cnt != ($clog2(QDepth+1))'(QDepth)) else $error("queue full on push");
    a_ready_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !out_ch.valid |=> out_ch.valid) else $error("queue not drained");
    a_stall_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt == ($clog2(QDepth+1))'(QDepth) |-> !in_ch.ready) else $error("ready when full");
endmodule
